@@ design/sc2a_pkg.sv @@
`default_nettype none

package sc2a_pkg;

    // Number of make codes covered by the lookup tables.
    localparam int unsigned TableKeysDefault = 89;

    // Bit of a scancode that marks a key release.
    localparam int unsigned ReleaseBit = 7;

    // Make codes with a special meaning.
    localparam logic [7:0] CODE_CTRL   = 8'h1D;
    localparam logic [7:0] CODE_LSHIFT = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT = 8'h36;
    localparam logic [7:0] CODE_CAPS   = 8'h3A;
    localparam logic [7:0] CODE_R      = 8'h13;

    // Character codes given for the left and right arrow keys.
    localparam logic [7:0] ARROW_LEFT  = 8'(8'h4B * 2);
    localparam logic [7:0] ARROW_RIGHT = 8'(8'h4D * 2);

    typedef struct packed {
        logic shift_held;
        logic control_held;
        logic caps_active;
    } flags_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       dump_request;
    } result_t;

    // Character for a make code with neither shift nor caps lock in effect.
    function automatic logic [7:0] plain_map(input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'd2:    ch = 8'h31;
            7'd3:    ch = 8'h32;
            7'd4:    ch = 8'h33;
            7'd5:    ch = 8'h34;
            7'd6:    ch = 8'h35;
            7'd7:    ch = 8'h36;
            7'd8:    ch = 8'h37;
            7'd9:    ch = 8'h38;
            7'd10:   ch = 8'h39;
            7'd11:   ch = 8'h30;
            7'd12:   ch = 8'h2D;
            7'd13:   ch = 8'h3D;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = 8'h71;
            7'd17:   ch = 8'h77;
            7'd18:   ch = 8'h65;
            7'd19:   ch = 8'h72;
            7'd20:   ch = 8'h74;
            7'd21:   ch = 8'h79;
            7'd22:   ch = 8'h75;
            7'd23:   ch = 8'h69;
            7'd24:   ch = 8'h6F;
            7'd25:   ch = 8'h70;
            7'd26:   ch = 8'h5B;
            7'd27:   ch = 8'h5D;
            7'd28:   ch = 8'h0A;
            7'd30:   ch = 8'h61;
            7'd31:   ch = 8'h73;
            7'd32:   ch = 8'h64;
            7'd33:   ch = 8'h66;
            7'd34:   ch = 8'h67;
            7'd35:   ch = 8'h68;
            7'd36:   ch = 8'h6A;
            7'd37:   ch = 8'h6B;
            7'd38:   ch = 8'h6C;
            7'd39:   ch = 8'h3B;
            7'd40:   ch = 8'h27;
            7'd41:   ch = 8'h60;
            7'd43:   ch = 8'h5C;
            7'd44:   ch = 8'h7A;
            7'd45:   ch = 8'h78;
            7'd46:   ch = 8'h63;
            7'd47:   ch = 8'h76;
            7'd48:   ch = 8'h62;
            7'd49:   ch = 8'h6E;
            7'd50:   ch = 8'h6D;
            7'd51:   ch = 8'h2C;
            7'd52:   ch = 8'h2E;
            7'd53:   ch = 8'h2F;
            7'd55:   ch = 8'h2A;
            7'd57:   ch = 8'h20;
            7'd75:   ch = ARROW_LEFT;
            7'd77:   ch = ARROW_RIGHT;
            7'd85:   ch = 8'h2B;
            7'd86:   ch = 8'h2B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Character for a make code with shift or caps lock in effect.
    function automatic logic [7:0] upper_map(input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'd2:    ch = 8'h21;
            7'd3:    ch = 8'h40;
            7'd4:    ch = 8'h23;
            7'd5:    ch = 8'h24;
            7'd6:    ch = 8'h25;
            7'd7:    ch = 8'h5E;
            7'd8:    ch = 8'h26;
            7'd9:    ch = 8'h2A;
            7'd10:   ch = 8'h28;
            7'd11:   ch = 8'h29;
            7'd12:   ch = 8'h5F;
            7'd13:   ch = 8'h2B;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = 8'h51;
            7'd17:   ch = 8'h57;
            7'd18:   ch = 8'h45;
            7'd19:   ch = 8'h52;
            7'd20:   ch = 8'h54;
            7'd21:   ch = 8'h59;
            7'd22:   ch = 8'h55;
            7'd23:   ch = 8'h49;
            7'd24:   ch = 8'h4F;
            7'd25:   ch = 8'h50;
            7'd26:   ch = 8'h7B;
            7'd27:   ch = 8'h7D;
            7'd28:   ch = 8'h0A;
            7'd30:   ch = 8'h41;
            7'd31:   ch = 8'h53;
            7'd32:   ch = 8'h44;
            7'd33:   ch = 8'h46;
            7'd34:   ch = 8'h47;
            7'd35:   ch = 8'h48;
            7'd36:   ch = 8'h4A;
            7'd37:   ch = 8'h4B;
            7'd38:   ch = 8'h4C;
            7'd39:   ch = 8'h3A;
            7'd40:   ch = 8'h22;
            7'd41:   ch = 8'h7E;
            7'd43:   ch = 8'h7C;
            7'd44:   ch = 8'h5A;
            7'd45:   ch = 8'h58;
            7'd46:   ch = 8'h43;
            7'd47:   ch = 8'h56;
            7'd48:   ch = 8'h42;
            7'd49:   ch = 8'h4E;
            7'd50:   ch = 8'h4D;
            7'd51:   ch = 8'h3C;
            7'd52:   ch = 8'h3E;
            7'd53:   ch = 8'h3F;
            7'd55:   ch = 8'h2A;
            7'd57:   ch = 8'h20;
            7'd75:   ch = ARROW_LEFT;
            7'd77:   ch = ARROW_RIGHT;
            7'd85:   ch = 8'h2A;
            7'd86:   ch = 8'h2A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ design/sc2a_scan_if.sv @@
`default_nettype none

interface sc2a_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scancode;

    modport source (output valid, output scancode, input ready);
    modport sink (input valid, input scancode, output ready);
endinterface

`default_nettype wire

@@ design/sc2a_char_if.sv @@
`default_nettype none

interface sc2a_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       dump_request;

    modport source (output valid, output char_code, output dump_request, input ready);
    modport sink (input valid, input char_code, input dump_request, output ready);
endinterface

`default_nettype wire

@@ design/scancode_to_ascii_translator.sv @@
`default_nettype none

// Set-1 keyboard scancode to character translator. Each beat on keys carries one raw
// scancode byte and produces exactly one beat on chars with an 8-bit character code and
// a dump_request bit. Shift, control and caps lock state is tracked internally and
// cleared by reset. Key releases, modifier presses, unmapped keys and make codes at or
// beyond TABLE_KEYS give character code 0; control together with R gives 0 and raises
// dump_request. The left and right arrows give 150 and 154. The block takes one beat
// per clock cycle while it does not stall: the scancode is captured in an input
// register, then translated by a table lookup while the modifier flags update, and the
// character is held in a result register until the sink takes it. The input register
// keeps accepting while a finished result waits, and stalls only when both registers
// are full and the sink does not take the result.
module scancode_to_ascii_translator
    import sc2a_pkg::*;
#(
    parameter int unsigned TABLE_KEYS = TableKeysDefault
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    sc2a_scan_if.sink keys,
    sc2a_char_if.source chars
);

    // Input stage.
    logic       in_valid_reg;
    logic [7:0] code_reg;

    // Result stage.
    logic       out_valid_reg;
    result_t    out_reg;

    result_t    decoded;
    logic       advance;
    logic       take;

    // A full input stage advances whenever the result register is empty or drained.
    assign advance = in_valid_reg & (~out_valid_reg | chars.ready);
    assign take    = keys.valid & keys.ready;

    assign keys.ready = ~in_valid_reg | advance;

    sc2a_decode #(
        .TABLE_KEYS(TABLE_KEYS)
    ) u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .code  (code_reg),
        .result(decoded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            code_reg <= keys.scancode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (chars.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= decoded;
        end
    end

    assign chars.valid        = out_valid_reg;
    assign chars.char_code    = out_reg.char_code;
    assign chars.dump_request = out_reg.dump_request;

`ifndef SYNTHESIS
    // A register dump request never comes with a printable character.
    assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.dump_request |-> chars.char_code == 8'h00)
    else $error("dump_request beat carries a nonzero character");

    // An empty input stage must always be able to take a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> keys.ready)
    else $error("input stage empty but not ready");

    // A release code moving into the result register gives character 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && code_reg[ReleaseBit] |=> out_reg.char_code == 8'h00)
    else $error("key release produced a nonzero character");

    // A held input stage keeps its scancode while the result side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(code_reg))
    else $error("stalled scancode lost or changed");
`endif

endmodule

`default_nettype wire

@@ design/sc2a_decode.sv @@
`default_nettype none

// Holds the modifier flags and translates one scancode; the flags advance on step.
module sc2a_decode
    import sc2a_pkg::*;
#(
    parameter int unsigned TABLE_KEYS = TableKeysDefault
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] code,
    output result_t         result
);

    localparam logic [7:0] KeyLimit = 8'(TABLE_KEYS);

    flags_t     flags_reg;
    flags_t     flags_next;
    logic [7:0] base;
    logic       shifted;

    assign base    = {1'b0, code[6:0]};
    assign shifted = flags_reg.caps_active | flags_reg.shift_held;

    always_comb
    begin
        flags_next          = flags_reg;
        result.char_code    = 8'h00;
        result.dump_request = 1'b0;
        if (code[ReleaseBit])
        begin
            if (base inside {CODE_LSHIFT, CODE_RSHIFT})
            begin
                flags_next.shift_held = 1'b0;
            end
            else if (base == CODE_CTRL)
            begin
                flags_next.control_held = 1'b0;
            end
        end
        else if (code == CODE_R && flags_reg.control_held)
        begin
            result.dump_request = 1'b1;
        end
        else if (code == CODE_CTRL)
        begin
            flags_next.control_held = 1'b1;
        end
        else if (code == CODE_CAPS)
        begin
            flags_next.caps_active = ~flags_reg.caps_active;
        end
        else if (code inside {CODE_LSHIFT, CODE_RSHIFT})
        begin
            flags_next.shift_held = 1'b1;
        end
        else if (code < KeyLimit)
        begin
            result.char_code = shifted ? upper_map(code[6:0]) : plain_map(code[6:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (step)
        begin
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import sc2a_pkg::*;

    // The block under test is built with the default table size, so the
    // predictor covers exactly that many make codes.
    localparam int unsigned KEY_COUNT = TableKeysDefault;

    // Bit 7 of a scancode marks a key release.
    localparam logic [7:0] KEY_RELEASE = 8'(1 << ReleaseBit);

    // Random beats per idling phase; four phases give about 1100 in total.
    localparam int PHASE_BEATS = 275;
    localparam int REPORT_LIMIT = 10;

    // Characters for make codes 0 up to KEY_COUNT - 1, written out in hex.
    // The first table applies with neither shift nor caps lock in effect,
    // the second with either of them.
    localparam logic [0:88][7:0] LOWER_KEYS = {
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h96, 8'h00, 8'h9A, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h2B, 8'h00,
        8'h00
    };

    localparam logic [0:88][7:0] UPPER_KEYS = {
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h96, 8'h00, 8'h9A, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2A, 8'h2A, 8'h00,
        8'h00
    };

    // One row of the directed part. Where has_fixed is set, the expected
    // character and dump bit are the typed-in ones; otherwise the predictor
    // supplies them. The predictor is stepped on every row either way, so
    // its flags follow the block.
    typedef struct {
        logic [7:0] code;
        bit         has_fixed;
        logic [7:0] char_code;
        logic       dump_request;
    } key_row_t;

    logic clk;
    logic rst_n;

    sc2a_scan_if keys_bus ();
    sc2a_char_if chars_bus ();

    scancode_to_ascii_translator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .keys  (keys_bus),
        .chars (chars_bus)
    );

    // Predictor state: the three keyboard flags as the block should hold them.
    logic shift_down;
    logic ctrl_down;
    logic caps_on;

    // Characters accepted on the input side whose beat on the output side
    // has not yet arrived, oldest first.
    result_t pending_chars [$];

    int error_count;
    int sender_idle_pct;
    int sink_stall_pct;

    key_row_t directed_rows [];

    // Works out the character for one scancode and updates the flags the way
    // the block does. A release only ever clears shift or control. Control
    // plus R raises the dump request and leaves the flags alone. Make codes
    // past the end of the tables give 0.
    function automatic result_t translate_scancode(input logic [7:0] code);
        result_t    res;
        logic [6:0] base;
        base = code[6:0];
        res.char_code = 8'h00;
        res.dump_request = 1'b0;
        if (code[ReleaseBit])
        begin
            if ({1'b0, base} == CODE_LSHIFT || {1'b0, base} == CODE_RSHIFT)
                shift_down = 1'b0;
            else if ({1'b0, base} == CODE_CTRL)
                ctrl_down = 1'b0;
        end
        else if (code == CODE_R && ctrl_down)
            res.dump_request = 1'b1;
        else if (code == CODE_CTRL)
            ctrl_down = 1'b1;
        else if (code == CODE_CAPS)
            caps_on = !caps_on;
        else if (code == CODE_LSHIFT || code == CODE_RSHIFT)
            shift_down = 1'b1;
        else if (code < KEY_COUNT)
            res.char_code = (caps_on || shift_down) ? UPPER_KEYS[code] : LOWER_KEYS[code];
        return res;
    endfunction

    // Random scancode, weighted toward sequences that exercise the flags:
    // typing keys, pressing and releasing modifiers, toggling caps lock and
    // the control-R combination. The rest is arbitrary bytes, which also
    // reach the make codes past the table and every bit pattern.
    function automatic logic [7:0] random_scancode();
        int         roll;
        logic [7:0] modifier;
        roll = $urandom_range(99);
        case ($urandom_range(2))
            0:       modifier = CODE_CTRL;
            1:       modifier = CODE_LSHIFT;
            default: modifier = CODE_RSHIFT;
        endcase
        if (roll < 45)
            return 8'($urandom_range(KEY_COUNT - 1));
        else if (roll < 55)
            return modifier;
        else if (roll < 65)
            return modifier | KEY_RELEASE;
        else if (roll < 70)
            return CODE_CAPS;
        else if (roll < 78)
            return CODE_R;
        else if (roll < 88)
            return KEY_RELEASE | 8'($urandom_range(127));
        return 8'($urandom_range(255));
    endfunction

    // Offers one scancode beat. It is entered and left at a falling edge.
    // The idle gap lowers valid; with no gap, valid stays high and only the
    // payload changes, so valid never gets two assignments in one step.
    // The expectation is queued at the rising edge that takes the beat.
    task automatic send_scancode(input logic [7:0] code, input key_row_t row,
                                 input bit from_row);
        result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            keys_bus.valid <= 1'b0;
            @(negedge clk);
        end
        keys_bus.valid <= 1'b1;
        keys_bus.scancode <= code;
        do
            @(posedge clk);
        while (!keys_bus.ready);
        predicted = translate_scancode(code);
        if (from_row && row.has_fixed)
        begin
            predicted.char_code = row.char_code;
            predicted.dump_request = row.dump_request;
        end
        pending_chars.push_back(predicted);
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // The sink's ready changes at falling edges only; its stall rate follows
    // the current phase.
    always @(negedge clk)
    begin
        chars_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Every character beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        result_t wanted;
        if (rst_n && chars_bus.valid && chars_bus.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected char beat: char_code=%h dump_request=%b",
                             chars_bus.char_code, chars_bus.dump_request);
            end
            else
            begin
                wanted = pending_chars.pop_front();
                if (chars_bus.char_code !== wanted.char_code ||
                    chars_bus.dump_request !== wanted.dump_request)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("char beat mismatch: expected %h/%b, got %h/%b",
                                 wanted.char_code, wanted.dump_request,
                                 chars_bus.char_code, chars_bus.dump_request);
                end
            end
        end
    end

    initial
    begin
        key_row_t no_row;
        int       drain_cycles;

        no_row = '{8'h00, 1'b0, 8'h00, 1'b0};

        // Directed part. It opens on a plain key straight after reset, walks
        // the ends of the code range and the edge of the tables, then goes
        // through each modifier, the caps lock toggle (which also shifts
        // digits and punctuation), control-R with and without control held,
        // a release of an ordinary key, and both arrows.
        directed_rows = '{
            '{8'h1E, 1'b1, 8'h61, 1'b0},
            '{8'h00, 1'b1, 8'h00, 1'b0},
            '{8'h7F, 1'b1, 8'h00, 1'b0},
            '{8'h58, 1'b1, 8'h00, 1'b0},
            '{8'h59, 1'b1, 8'h00, 1'b0},
            '{8'hFF, 1'b1, 8'h00, 1'b0},
            '{8'h80, 1'b1, 8'h00, 1'b0},
            '{CODE_LSHIFT, 1'b1, 8'h00, 1'b0},
            '{8'h1E, 1'b1, 8'h41, 1'b0},
            '{CODE_LSHIFT | KEY_RELEASE, 1'b1, 8'h00, 1'b0},
            '{CODE_RSHIFT, 1'b1, 8'h00, 1'b0},
            '{8'h02, 1'b1, 8'h21, 1'b0},
            '{CODE_RSHIFT | KEY_RELEASE, 1'b1, 8'h00, 1'b0},
            '{8'h02, 1'b1, 8'h31, 1'b0},
            '{CODE_CAPS, 1'b1, 8'h00, 1'b0},
            '{8'h35, 1'b0, 8'h00, 1'b0},
            '{8'h9E, 1'b1, 8'h00, 1'b0},
            '{CODE_CAPS, 1'b1, 8'h00, 1'b0},
            '{CODE_CTRL, 1'b1, 8'h00, 1'b0},
            '{CODE_R, 1'b1, 8'h00, 1'b1},
            '{8'h1E, 1'b0, 8'h00, 1'b0},
            '{CODE_CTRL | KEY_RELEASE, 1'b1, 8'h00, 1'b0},
            '{CODE_R, 1'b0, 8'h00, 1'b0},
            '{8'h4B, 1'b1, ARROW_LEFT, 1'b0},
            '{8'h4D, 1'b1, ARROW_RIGHT, 1'b0},
            '{8'h56, 1'b0, 8'h00, 1'b0}
        };

        // All inputs known from the start; reset held low at first, then released.
        rst_n = 1'b0;
        keys_bus.valid = 1'b0;
        keys_bus.scancode = 8'h00;
        chars_bus.ready = 1'b0;
        error_count = 0;
        sender_idle_pct = 0;
        sink_stall_pct = 0;
        shift_down = 1'b0;
        ctrl_down = 1'b0;
        caps_on = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_scancode(directed_rows[i].code, directed_rows[i], 1'b1);

        // Random part in four idling phases: none, a mostly idle sender,
        // a mostly stalled sink, then both idling now and then.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin sender_idle_pct = 82; sink_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin sender_idle_pct = 11; sink_stall_pct = 11; end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++)
                send_scancode(random_scancode(), no_row, 1'b0);
        end
        keys_bus.valid <= 1'b0;

        // Drain with the sink always ready, then let the two-stage pipeline
        // settle so that a stray extra beat would still be seen.
        sink_stall_pct = 0;
        drain_cycles = 0;
        while (pending_chars.size() != 0 && drain_cycles < 10000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (20) @(posedge clk);

        if (error_count == 0 && pending_chars.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog. Even with the slowest phases, the whole run fits well
    // inside this bound.
    initial
    begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
design/sc2a_pkg.sv
design/sc2a_scan_if.sv
design/sc2a_char_if.sv
design/sc2a_decode.sv
design/scancode_to_ascii_translator.sv
sim/testbench.sv
